// File: rtl/core/sound_cpu_bus_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// Sound CPU bus decoder assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during rst_n low.
// ----------------------------------------------------------------------------
`ifndef SOUND_CPU_BUS_DECODER_CORE_MACROS_SVH
`define SOUND_CPU_BUS_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define SCBD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/scbd_pkg.sv
// ----------------------------------------------------------------------------
// Sound CPU bus decoder package
// Access modes, target codes, address map constants and shared structs.
// ----------------------------------------------------------------------------
package scbd_pkg;

  typedef enum logic [2:0] {
    MODE_CPU_RD    = 3'd0,
    MODE_CPU_WR    = 3'd1,
    MODE_HOST_RD_B = 3'd2,
    MODE_HOST_WR_B = 3'd3,
    MODE_HOST_RD_W = 3'd4,
    MODE_HOST_WR_W = 3'd5,
    MODE_CTRL_RD   = 3'd6,
    MODE_CTRL_WR   = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    TGT_INTERNAL = 3'd0,
    TGT_FM       = 3'd1,
    TGT_BANKREG  = 3'd2,
    TGT_PSG      = 3'd3,
    TGT_BANKED   = 3'd4,
    TGT_UNMAPPED = 3'd5
  } target_t;

  localparam logic [15:0] FM_BASE      = 16'h4000;
  localparam logic [15:0] BANKREG_BASE = 16'h6000;
  localparam logic [15:0] GAP_BASE     = 16'h6100;
  localparam logic [15:0] PSG_BASE     = 16'h7F00;
  localparam logic [15:0] PSG_LAST     = 16'h7F1F;
  localparam logic [15:0] HOSTWIN_BASE = 16'h8000;

  localparam logic [15:0] CTRL_BUSREQ    = 16'h1100;
  localparam logic [15:0] CTRL_BUSREQ_LO = 16'h1101;
  localparam logic [15:0] CTRL_RESET     = 16'h1200;
  localparam logic [15:0] CTRL_RESET_LO  = 16'h1201;

  localparam logic [15:0] UNMAPPED_DATA = 16'h00FF;

  localparam int BANK_BITS = 9;
  localparam int WIN_BITS  = 15;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    target_t      target;
    logic [23:0]  ext_address;
    logic         ext_write;
    logic [15:0]  read_data;
    logic         cpu_reset_pulse;
    logic         cpu_may_run;
  } result_t;

endpackage

// File: rtl/core/scbd_if.sv
// ----------------------------------------------------------------------------
// Sound CPU bus decoder channels
// Valid/ready request channel and result channel.
// ----------------------------------------------------------------------------
interface scbd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] address;
  logic [15:0] data;

  modport source (output valid, output mode, output address, output data, input ready);
  modport sink   (input valid, input mode, input address, input data, output ready);
endinterface

interface scbd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [23:0] ext_address;
  logic        ext_write;
  logic [15:0] read_data;
  logic        cpu_reset_pulse;
  logic        cpu_may_run;

  modport source (output valid, output target, output ext_address, output ext_write,
                  output read_data, output cpu_reset_pulse, output cpu_may_run,
                  input ready);
  modport sink   (input valid, input target, input ext_address, input ext_write,
                  input read_data, input cpu_reset_pulse, input cpu_may_run,
                  output ready);
endinterface

// File: rtl/core/scbd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one read per cycle at the shared address, registered read data.
// ----------------------------------------------------------------------------
module scbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/scbd_ctrl.sv
// ----------------------------------------------------------------------------
// Sound CPU bus decoder controller
// Sequences capture of a request and commit of its result into the output slot.
// ----------------------------------------------------------------------------
module scbd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output scbd_pkg::ctrl_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.capture   = (state_r == S_IDLE) && in_valid;
    cmd.commit    = (state_r == S_RESP) && (!out_valid_r || out_ready);
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (cmd.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/scbd_dp.sv
// ----------------------------------------------------------------------------
// Sound CPU bus decoder datapath
// Even/odd RAM banks, address decode, bank and control registers, result slot.
// ----------------------------------------------------------------------------
module scbd_dp #(
  parameter int RAM_ADDR_BITS = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  scbd_pkg::ctrl_cmd_t cmd,
  input  logic [2:0]          in_mode,
  input  logic [15:0]         in_address,
  input  logic [15:0]         in_data,
  output scbd_pkg::result_t   res
);

  localparam int B     = RAM_ADDR_BITS;
  localparam int BANKD = 2 ** (B - 1);

  scbd_pkg::mode_t mode_in, mode_r;
  logic [15:0]     addr_r;
  logic [15:0]     data_r;
  logic            lsb_r;

  logic [B-1:0]    a0;
  logic [B-1:0]    a1;
  logic            is_word;
  logic            ram_wr;
  logic            we_even;
  logic            we_odd;
  logic [B-2:0]    idx_even;
  logic [B-2:0]    idx_odd;
  logic [7:0]      wd_even;
  logic [7:0]      wd_odd;
  logic [7:0]      q_even;
  logic [7:0]      q_odd;
  logic [7:0]      byte_q;
  logic [15:0]     word_q;

  logic [scbd_pkg::BANK_BITS-1:0] bank_r, bank_nxt;
  logic                           busreq_r, busreq_nxt;
  logic                           held_r, held_nxt;
  logic                           released_r, released_nxt;

  scbd_pkg::result_t res_r, res_nxt;

  always_comb begin
    mode_in  = scbd_pkg::mode_t'(in_mode);
    a0       = in_address[B-1:0];
    a1       = a0 + {{(B-1){1'b0}}, 1'b1};
    is_word  = mode_in inside {scbd_pkg::MODE_HOST_RD_W, scbd_pkg::MODE_HOST_WR_W};
    ram_wr   = ((mode_in == scbd_pkg::MODE_CPU_WR) && (in_address < scbd_pkg::FM_BASE)) ||
               (mode_in inside {scbd_pkg::MODE_HOST_WR_B, scbd_pkg::MODE_HOST_WR_W});
    we_even  = cmd.capture && ram_wr && (is_word || !a0[0]);
    we_odd   = cmd.capture && ram_wr && (is_word || a0[0]);
    idx_odd  = a0[B-1:1];
    idx_even = a0[0] ? a1[B-1:1] : a0[B-1:1];
    wd_even  = (is_word && !a0[0]) ? in_data[15:8] : in_data[7:0];
    wd_odd   = (is_word && a0[0]) ? in_data[15:8] : in_data[7:0];
  end

  scbd_ram #(.WIDTH(8), .DEPTH(BANKD)) u_ram_even (
    .clk   (clk),
    .we    (we_even),
    .re    (cmd.capture),
    .addr  (idx_even),
    .wdata (wd_even),
    .rdata (q_even)
  );

  scbd_ram #(.WIDTH(8), .DEPTH(BANKD)) u_ram_odd (
    .clk   (clk),
    .we    (we_odd),
    .re    (cmd.capture),
    .addr  (idx_odd),
    .wdata (wd_odd),
    .rdata (q_odd)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= mode_in;
      addr_r <= in_address;
      data_r <= in_data;
      lsb_r  <= a0[0];
    end
  end

  always_comb begin
    byte_q                  = lsb_r ? q_odd : q_even;
    word_q                  = lsb_r ? {q_odd, q_even} : {q_even, q_odd};
    bank_nxt                = bank_r;
    busreq_nxt              = busreq_r;
    held_nxt                = held_r;
    released_nxt            = released_r;
    res_nxt.target          = scbd_pkg::TGT_INTERNAL;
    res_nxt.ext_address     = '0;
    res_nxt.ext_write       = 1'b0;
    res_nxt.read_data       = '0;
    res_nxt.cpu_reset_pulse = 1'b0;
    case (mode_r)
      scbd_pkg::MODE_CPU_RD, scbd_pkg::MODE_CPU_WR: begin
        if (addr_r < scbd_pkg::FM_BASE) begin
          if (mode_r == scbd_pkg::MODE_CPU_RD) begin
            res_nxt.read_data = {8'd0, byte_q};
          end
        end else if (addr_r < scbd_pkg::BANKREG_BASE) begin
          res_nxt.target      = scbd_pkg::TGT_FM;
          res_nxt.ext_address = {22'd0, addr_r[1:0]};
          res_nxt.ext_write   = (mode_r == scbd_pkg::MODE_CPU_WR);
        end else if (addr_r < scbd_pkg::GAP_BASE) begin
          res_nxt.target = scbd_pkg::TGT_BANKREG;
          if (mode_r == scbd_pkg::MODE_CPU_WR) begin
            bank_nxt = {data_r[0], bank_r[scbd_pkg::BANK_BITS-1:1]};
          end else begin
            res_nxt.read_data = {{(16 - scbd_pkg::BANK_BITS){1'b0}}, bank_r};
          end
        end else if (addr_r >= scbd_pkg::HOSTWIN_BASE) begin
          res_nxt.target      = scbd_pkg::TGT_BANKED;
          res_nxt.ext_address = {bank_r, addr_r[scbd_pkg::WIN_BITS-1:0]};
          res_nxt.ext_write   = (mode_r == scbd_pkg::MODE_CPU_WR);
        end else if ((mode_r == scbd_pkg::MODE_CPU_WR) &&
                     (addr_r inside {[scbd_pkg::PSG_BASE:scbd_pkg::PSG_LAST]})) begin
          res_nxt.target    = scbd_pkg::TGT_PSG;
          res_nxt.ext_write = 1'b1;
        end else begin
          res_nxt.target = scbd_pkg::TGT_UNMAPPED;
          if (mode_r == scbd_pkg::MODE_CPU_RD) begin
            res_nxt.read_data = scbd_pkg::UNMAPPED_DATA;
          end
        end
      end
      scbd_pkg::MODE_HOST_RD_B: res_nxt.read_data = {8'd0, byte_q};
      scbd_pkg::MODE_HOST_WR_B: res_nxt.read_data = '0;
      scbd_pkg::MODE_HOST_RD_W: res_nxt.read_data = word_q;
      scbd_pkg::MODE_HOST_WR_W: res_nxt.read_data = '0;
      scbd_pkg::MODE_CTRL_RD: begin
        if (addr_r == scbd_pkg::CTRL_BUSREQ) begin
          res_nxt.read_data = {15'd0, !busreq_r};
        end else if (addr_r == scbd_pkg::CTRL_RESET) begin
          res_nxt.read_data = {15'd0, held_r};
        end else if (addr_r inside {scbd_pkg::CTRL_BUSREQ_LO, scbd_pkg::CTRL_RESET_LO}) begin
          res_nxt.read_data = '0;
        end else begin
          res_nxt.read_data = scbd_pkg::UNMAPPED_DATA;
        end
      end
      scbd_pkg::MODE_CTRL_WR: begin
        if (addr_r == scbd_pkg::CTRL_BUSREQ) begin
          busreq_nxt = (data_r != 16'd0);
        end else if (addr_r == scbd_pkg::CTRL_RESET) begin
          if (data_r == 16'd0) begin
            held_nxt = 1'b1;
          end else begin
            held_nxt                = 1'b0;
            released_nxt            = 1'b1;
            res_nxt.cpu_reset_pulse = 1'b1;
          end
        end
      end
      default: res_nxt.target = scbd_pkg::TGT_INTERNAL;
    endcase
    res_nxt.cpu_may_run = released_nxt && !held_nxt && !busreq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r     <= '0;
      busreq_r   <= 1'b0;
      held_r     <= 1'b1;
      released_r <= 1'b0;
    end else if (cmd.commit) begin
      bank_r     <= bank_nxt;
      busreq_r   <= busreq_nxt;
      held_r     <= held_nxt;
      released_r <= released_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// File: rtl/core/sound_cpu_bus_decoder_core.sv
// ----------------------------------------------------------------------------
// Sound CPU bus decoder core
// Timing: an accepted request is captured with a registered read of the RAM
// banks, then committed to the result slot once it is free; only then is the next request taken.
// Reset: synchronous active-low rst_n clears bank, busreq, released; sets held.
// ----------------------------------------------------------------------------
module sound_cpu_bus_decoder_core #(
  parameter int RAM_ADDR_BITS = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  scbd_in_if.sink           in_ch,
  scbd_out_if.source        out_ch
);

  scbd_pkg::ctrl_cmd_t cmd;
  scbd_pkg::result_t   res;

  scbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  scbd_dp #(.RAM_ADDR_BITS(RAM_ADDR_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_mode    (in_ch.mode),
    .in_address (in_ch.address),
    .in_data    (in_ch.data),
    .res        (res)
  );

  assign out_ch.target          = res.target;
  assign out_ch.ext_address     = res.ext_address;
  assign out_ch.ext_write       = res.ext_write;
  assign out_ch.read_data       = res.read_data;
  assign out_ch.cpu_reset_pulse = res.cpu_reset_pulse;
  assign out_ch.cpu_may_run     = res.cpu_may_run;

endmodule

// File: rtl/core/scbd_checker.sv
// ----------------------------------------------------------------------------
// Sound CPU bus decoder checker
// Port-level assertions on request and result channels, bound to the core.
// ----------------------------------------------------------------------------
`include "sound_cpu_bus_decoder_core_macros.svh"

module scbd_port_checker (
  input logic        clk,
  input logic        rst_n,
  scbd_in_if.sink    in_ch,
  scbd_out_if.source out_ch
);

  `SCBD_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid,
                    "result dropped while stalled")
  `SCBD_ASSERT_NEXT(a_one_at_a_time, in_ch.valid && in_ch.ready, !in_ch.ready,
                    "request taken while one is in flight")
  `SCBD_ASSERT_IMPL(a_ext_write_target, out_ch.valid && out_ch.ext_write,
                    (out_ch.target == scbd_pkg::TGT_FM) ||
                    (out_ch.target == scbd_pkg::TGT_PSG) ||
                    (out_ch.target == scbd_pkg::TGT_BANKED),
                    "write strobe on a non-external target")
  `SCBD_ASSERT_IMPL(a_pulse_clean, out_ch.valid && out_ch.cpu_reset_pulse,
                    (out_ch.target == scbd_pkg::TGT_INTERNAL) && !out_ch.ext_write &&
                    (out_ch.read_data == 16'd0),
                    "reset pulse on a non-control result")

endmodule

bind sound_cpu_bus_decoder_core scbd_port_checker u_scbd_port_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

// File: bench/scbd_checker.sv
// ----------------------------------------------------------------------------
// Sound CPU bus decoder checker
// Watches the request and result channels, decodes every accepted request
// against its own copy of the RAM, bank register and control flags, and
// compares each result field by field with the oldest decoded access.
// ----------------------------------------------------------------------------
module scbd_checker
  import scbd_pkg::*;
#(
  parameter int RAM_ADDR_BITS = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  scbd_in_if          in_ch,
  scbd_out_if         out_ch,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  localparam int RAM_WORDS = 1 << RAM_ADDR_BITS;
  localparam int RAM_MASK  = RAM_WORDS - 1;

  logic [7:0]           sram [RAM_WORDS];
  logic [BANK_BITS-1:0] bank_reg;
  logic                 busreq_flag;
  logic                 hold_flag;
  logic                 released_flag;
  result_t              decoded_q [$];
  result_t              want;

  function automatic result_t decode_access(mode_t m, logic [15:0] a, logic [15:0] d);
    result_t r;
    logic    wr;
    int      ofs;
    r        = '0;
    r.target = TGT_INTERNAL;
    wr       = (m == MODE_CPU_WR);
    ofs      = int'(a) & RAM_MASK;
    case (m)
      MODE_CPU_RD, MODE_CPU_WR: begin
        if (a < FM_BASE) begin
          if (wr) sram[ofs] = d[7:0];
          else r.read_data = {8'h00, sram[ofs]};
        end else if (a < BANKREG_BASE) begin
          r.target      = TGT_FM;
          r.ext_address = {22'd0, a[1:0]};
          r.ext_write   = wr;
        end else if (a < GAP_BASE) begin
          r.target = TGT_BANKREG;
          if (wr) bank_reg = {d[0], bank_reg[BANK_BITS-1:1]};
          else r.read_data = {7'd0, bank_reg};
        end else if (a >= HOSTWIN_BASE) begin
          r.target      = TGT_BANKED;
          r.ext_address = {bank_reg, a[WIN_BITS-1:0]};
          r.ext_write   = wr;
        end else if (wr && a >= PSG_BASE && a <= PSG_LAST) begin
          r.target    = TGT_PSG;
          r.ext_write = 1'b1;
        end else begin
          r.target    = TGT_UNMAPPED;
          r.read_data = wr ? 16'h0000 : UNMAPPED_DATA;
        end
      end
      MODE_HOST_RD_B: r.read_data = {8'h00, sram[ofs]};
      MODE_HOST_WR_B: sram[ofs] = d[7:0];
      MODE_HOST_RD_W: r.read_data = {sram[ofs], sram[(ofs + 1) & RAM_MASK]};
      MODE_HOST_WR_W: begin
        sram[ofs]                    = d[15:8];
        sram[(ofs + 1) & RAM_MASK]   = d[7:0];
      end
      MODE_CTRL_RD: begin
        if (a == CTRL_BUSREQ) r.read_data = {15'd0, !busreq_flag};
        else if (a == CTRL_RESET) r.read_data = {15'd0, hold_flag};
        else if (a == CTRL_BUSREQ_LO || a == CTRL_RESET_LO) r.read_data = 16'h0000;
        else r.read_data = UNMAPPED_DATA;
      end
      default: begin
        if (a == CTRL_BUSREQ) begin
          busreq_flag = (d != 16'h0000);
        end else if (a == CTRL_RESET) begin
          if (d == 16'h0000) begin
            hold_flag = 1'b1;
          end else begin
            hold_flag         = 1'b0;
            released_flag     = 1'b1;
            r.cpu_reset_pulse = 1'b1;
          end
        end
      end
    endcase
    r.cpu_may_run = released_flag && !hold_flag && !busreq_flag;
    return r;
  endfunction

  function automatic void check_field(string name, logic [23:0] exp_v, logic [23:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      bank_reg      = '0;
      busreq_flag   = 1'b0;
      hold_flag     = 1'b1;
      released_flag = 1'b0;
      decoded_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        decoded_q.push_back(decode_access(mode_t'(in_ch.mode), in_ch.address, in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          check_field("target", 24'(want.target), 24'(out_ch.target));
          check_field("ext_address", want.ext_address, out_ch.ext_address);
          check_field("ext_write", 24'(want.ext_write), 24'(out_ch.ext_write));
          check_field("read_data", 24'(want.read_data), 24'(out_ch.read_data));
          check_field("cpu_reset_pulse", 24'(want.cpu_reset_pulse),
                      24'(out_ch.cpu_reset_pulse));
          check_field("cpu_may_run", 24'(want.cpu_may_run), 24'(out_ch.cpu_may_run));
        end
      end
    end
    outstanding = decoded_q.size();
  end

endmodule

// File: bench/tb_sound_cpu_bus_decoder_core.sv
// ----------------------------------------------------------------------------
// Sound CPU bus decoder testbench
// Drives directed accesses over every region, mode and control register, then
// random bus traffic with bursts of idle and stall on both channels, a full
// drain in the middle and a calm closing stretch. Checking lives in the checker.
// ----------------------------------------------------------------------------
module tb_sound_cpu_bus_decoder_core;
  import scbd_pkg::*;

  localparam int RAM_ADDR_BITS = 13;
  localparam int RAM_WORDS     = 1 << RAM_ADDR_BITS;
  localparam int RAM_MASK      = RAM_WORDS - 1;
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_count;
  bit          quiet;
  bit          ram_loaded [RAM_WORDS];
  int          loaded_ofs [$];

  scbd_in_if  in_ch ();
  scbd_out_if out_ch ();

  sound_cpu_bus_decoder_core #(
    .RAM_ADDR_BITS(RAM_ADDR_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  scbd_checker #(
    .RAM_ADDR_BITS(RAM_ADDR_BITS)
  ) i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void note_loaded(int ofs);
    if (!ram_loaded[ofs & RAM_MASK]) begin
      ram_loaded[ofs & RAM_MASK] = 1'b1;
      loaded_ofs.push_back(ofs & RAM_MASK);
    end
  endfunction

  function automatic int pick_loaded();
    return loaded_ofs[$urandom_range(0, loaded_ofs.size() - 1)];
  endfunction

  task automatic put_request(mode_t m, logic [15:0] a, logic [15:0] d);
    case (m)
      MODE_CPU_WR: if (a < FM_BASE) note_loaded(int'(a));
      MODE_HOST_WR_B: note_loaded(int'(a));
      MODE_HOST_WR_W: begin
        note_loaded(int'(a));
        note_loaded(int'(a) + 1);
      end
      default: ;
    endcase
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= m;
    in_ch.address <= a;
    in_ch.data    <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_request();
    mode_t       m;
    logic [15:0] a;
    logic [15:0] d;
    int          ofs;
    m = mode_t'($urandom_range(0, 7));
    a = 16'($urandom);
    d = 16'($urandom);
    case (m)
      MODE_CPU_RD, MODE_CPU_WR: begin
        case ($urandom_range(0, 7))
          0, 1: begin
            if (loaded_ofs.size() == 0) m = MODE_CPU_WR;
            if (m == MODE_CPU_RD) a = ((a << RAM_ADDR_BITS) | 16'(pick_loaded())) & 16'h3FFF;
            else a = a & 16'h3FFF;
          end
          2: a = 16'($urandom_range(FM_BASE, BANKREG_BASE - 1));
          3: a = 16'($urandom_range(BANKREG_BASE, GAP_BASE - 1));
          4: a = 16'($urandom_range(PSG_BASE, PSG_LAST));
          5: a = 16'($urandom_range(GAP_BASE, HOSTWIN_BASE - 1));
          default: a[15] = 1'b1;
        endcase
      end
      MODE_HOST_RD_B: begin
        if (loaded_ofs.size() == 0) m = MODE_HOST_WR_B;
        else a = (a << RAM_ADDR_BITS) | 16'(pick_loaded());
      end
      MODE_HOST_RD_W: begin
        if (loaded_ofs.size() == 0) begin
          m = MODE_HOST_WR_W;
        end else begin
          ofs = pick_loaded();
          if (!ram_loaded[(ofs + 1) & RAM_MASK]) m = MODE_HOST_WR_W;
          a = (a << RAM_ADDR_BITS) | 16'(ofs);
        end
      end
      MODE_CTRL_RD, MODE_CTRL_WR: begin
        case ($urandom_range(0, 5))
          0, 1: a = CTRL_BUSREQ;
          2, 3: a = CTRL_RESET;
          4: a = $urandom_range(0, 1) ? CTRL_BUSREQ_LO : CTRL_RESET_LO;
          default: ;
        endcase
        if ($urandom_range(0, 2) == 0) d = 16'h0000;
      end
      default: ;
    endcase
    put_request(m, a, d);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  initial begin
    rst_n         = 1'b0;
    quiet         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.mode    = MODE_CPU_RD;
    in_ch.address = 16'h0000;
    in_ch.data    = 16'h0000;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    put_request(MODE_CTRL_RD, CTRL_BUSREQ, 16'h0000);
    put_request(MODE_CTRL_RD, CTRL_RESET, 16'h0000);
    put_request(MODE_CTRL_RD, CTRL_BUSREQ_LO, 16'h0000);
    put_request(MODE_CTRL_RD, CTRL_RESET_LO, 16'h0000);
    put_request(MODE_CTRL_RD, 16'hFFFF, 16'hFFFF);
    put_request(MODE_CTRL_WR, CTRL_RESET, 16'h8000);
    put_request(MODE_CTRL_WR, CTRL_BUSREQ, 16'h0100);
    put_request(MODE_CTRL_RD, CTRL_BUSREQ, 16'h0000);
    put_request(MODE_CTRL_WR, CTRL_BUSREQ, 16'h0000);
    put_request(MODE_CTRL_WR, 16'h0000, 16'hFFFF);
    put_request(MODE_HOST_WR_B, 16'hFFFF, 16'hFFAB);
    put_request(MODE_HOST_WR_W, 16'h1FFF, 16'h1234);
    put_request(MODE_HOST_RD_W, 16'hFFFF, 16'h0000);
    put_request(MODE_CPU_WR, 16'h2000, 16'hFFCD);
    put_request(MODE_CPU_RD, 16'h3FFF, 16'h0000);
    put_request(MODE_HOST_RD_B, 16'h0000, 16'h0000);
    put_request(MODE_CPU_WR, 16'h4003, 16'h00A5);
    put_request(MODE_CPU_RD, 16'h5FFC, 16'h0000);
    put_request(MODE_CPU_WR, BANKREG_BASE, 16'h0001);
    put_request(MODE_CPU_WR, 16'h60FF, 16'hFFFE);
    put_request(MODE_CPU_RD, 16'h6080, 16'h0000);
    put_request(MODE_CPU_WR, PSG_LAST, 16'h005A);
    put_request(MODE_CPU_RD, PSG_BASE, 16'h0000);
    put_request(MODE_CPU_WR, 16'h7F20, 16'h0033);
    put_request(MODE_CPU_RD, GAP_BASE, 16'h0000);
    put_request(MODE_CPU_WR, HOSTWIN_BASE, 16'h00FF);
    put_request(MODE_CPU_RD, 16'hFFFF, 16'h0000);
    put_request(MODE_CTRL_WR, CTRL_RESET, 16'h0000);

    repeat (500) random_request();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (200) random_request();
    quiet = 1'b1;
    repeat (300) random_request();

    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/scbd_pkg.sv
rtl/core/scbd_if.sv
rtl/core/scbd_ram.sv
rtl/core/scbd_ctrl.sv
rtl/core/scbd_dp.sv
rtl/core/sound_cpu_bus_decoder_core.sv
rtl/core/scbd_checker.sv
bench/scbd_checker.sv
bench/tb_sound_cpu_bus_decoder_core.sv
